[hdl/resample_voice_mix_lerp_top_macros.svh]
// ----------------------------------------------------------------------------
// resample_voice_mix_lerp_top_macros
// assertion macros of the voice mixer top, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef RESAMPLE_VOICE_MIX_LERP_TOP_MACROS_SVH
`define RESAMPLE_VOICE_MIX_LERP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define RVML_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RVML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RVML_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RVML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/rvml_pkg.sv]
// ----------------------------------------------------------------------------
// rvml_pkg
// types and constants of the interpolating voice resampler and mixer
// ----------------------------------------------------------------------------
package rvml_pkg;

   typedef logic [1:0]         cmd_type;
   typedef logic signed [15:0] sample_type;
   typedef logic signed [23:0] mix_type;
   typedef logic [3:0]         csr_addr_type;
   typedef logic [31:0]        csr_data_type;

   localparam cmd_type CMD_LOAD = 2'd0;
   localparam cmd_type CMD_SET  = 2'd1;
   localparam cmd_type CMD_MIX  = 2'd2;

   localparam logic [1:0] REG_LENGTH = 2'd0;
   localparam logic [1:0] REG_STEP   = 2'd1;
   localparam logic [1:0] REG_GAIN   = 2'd2;

   localparam logic [16:0] LENGTH_RST = 17'd0;
   localparam logic [23:0] STEP_RST   = 24'd65536;
   localparam logic [15:0] GAIN_RST   = 16'd32768;

   localparam mix_type MIX_MAX = 24'sh7FFFFF;
   localparam mix_type MIX_MIN = 24'sh800000;

   localparam logic signed [48:0] ROUND_HALF = 49'sd1073741824;

endpackage

[hdl/rvml_sample_ram.sv]
// ----------------------------------------------------------------------------
// rvml_sample_ram
// voice sample memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rvml_sample_ram #(
   parameter int DEPTH = 65536
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  rvml_pkg::sample_type      wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output rvml_pkg::sample_type      rd_data_a,
   output rvml_pkg::sample_type      rd_data_b
);
   import rvml_pkg::*;

   sample_type mem [DEPTH];
   sample_type rd_a_ff;
   sample_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hdl/resample_voice_mix_lerp_top.sv]
// ----------------------------------------------------------------------------
// resample_voice_mix_lerp_top
// mixes one linearly interpolated mono voice into a stereo pair
// ----------------------------------------------------------------------------
// load, set and ended mix items: result via S_FIN to the output register; req_stall holds until then
// active mix items: result via S_LERP, S_BLEND, S_GAIN, S_ROUND and S_FIN, likewise stalling; the
//    steps are the sample memory read, the lerp multiply, the blend add, the gain multiply
//    and the round stage
// an item is taken while a finished result still waits at the output register
// synchronous reset clears control, position, fraction and registers to defaults;
//    the sample memory is not cleared
`include "resample_voice_mix_lerp_top_macros.svh"

module resample_voice_mix_lerp_top #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rvml_pkg::cmd_type      req_command,
   input  logic [15:0]            req_sample_address,
   input  rvml_pkg::sample_type   req_sample_value,
   input  logic [15:0]            req_start_position,
   input  logic [15:0]            req_start_fraction,
   input  rvml_pkg::mix_type      req_mix_in_left,
   input  rvml_pkg::mix_type      req_mix_in_right,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rvml_pkg::mix_type      rsp_mix_out_left,
   output rvml_pkg::mix_type      rsp_mix_out_right,
   output logic                   rsp_sample_ended,
   output logic                   rsp_clipped,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  rvml_pkg::csr_addr_type csr_paddr,
   input  rvml_pkg::csr_data_type csr_pwdata,
   output rvml_pkg::csr_data_type csr_prdata,
   output logic                   csr_pready
);
   import rvml_pkg::*;

   localparam int          ADDR_W  = $clog2(SAMPLE_DEPTH);
   localparam logic [16:0] DEPTH_L = 17'(SAMPLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LERP,
      S_BLEND,
      S_GAIN,
      S_ROUND,
      S_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [16:0] len_ff;
   logic [23:0] step_ff;
   logic [15:0] gain_ff;
   logic [16:0] pos_ff;
   logic [16:0] pos_in;
   logic [15:0] frac_ff;
   logic [15:0] frac_in;

   logic [15:0] wfrac_ff;
   logic signed [33:0] prod_ff;
   logic signed [31:0] v_ff;
   logic signed [48:0] p_ff;

   mix_type res_left_ff;
   mix_type res_right_ff;
   logic    res_ended_ff;
   logic    res_clip_ff;

   logic    rsp_valid_ff;
   mix_type rsp_left_ff;
   mix_type rsp_right_ff;
   logic    rsp_ended_ff;
   logic    rsp_clip_ff;

   logic        accept;
   logic        out_free;
   logic [16:0] len_eff;
   logic [17:0] pos_next1;
   logic        ended_w;
   logic        mix_go;
   logic        load_ok;
   logic [16:0] frac_sum;
   logic        csr_wr;

   sample_type s0;
   sample_type s1;
   logic signed [16:0] diff_w;
   logic signed [33:0] prod_w;
   logic signed [33:0] vsum_w;
   logic signed [48:0] p_w;
   logic signed [48:0] psum_w;
   logic signed [17:0] c_w;
   logic signed [24:0] sum_l;
   logic signed [24:0] sum_r;
   mix_type sat_l;
   mix_type sat_r;
   logic    clip_l;
   logic    clip_r;

   // handshake and control
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign len_eff   = (len_ff > DEPTH_L) ? DEPTH_L : len_ff;
   assign pos_next1 = {1'b0, pos_ff} + 18'd1;
   assign ended_w   = (pos_next1 >= {1'b0, len_eff});
   assign mix_go    = accept && (req_command == CMD_MIX) && !ended_w;
   assign load_ok   = ({1'b0, req_sample_address} < DEPTH_L);
   assign frac_sum  = {1'b0, frac_ff} + {1'b0, step_ff[15:0]};

   always_comb begin
      pos_in  = pos_ff;
      frac_in = frac_ff;
      if (accept && (req_command == CMD_SET)) begin
         pos_in  = {1'b0, req_start_position};
         frac_in = req_start_fraction;
      end else if (mix_go) begin
         pos_in  = pos_ff + {9'd0, step_ff[23:16]} + {16'd0, frac_sum[16]};
         frac_in = frac_sum[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (mix_go) begin
               state_in = S_LERP;
            end else if (accept) begin
               state_in = S_FIN;
            end
         end
         S_LERP:  state_in = S_BLEND;
         S_BLEND: state_in = S_GAIN;
         S_GAIN:  state_in = S_ROUND;
         S_ROUND: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   rvml_sample_ram #(
      .DEPTH(SAMPLE_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (accept && (req_command == CMD_LOAD) && load_ok),
      .wr_addr   (req_sample_address[ADDR_W-1:0]),
      .wr_data   (req_sample_value),
      .rd_en     (mix_go),
      .rd_addr_a (pos_ff[ADDR_W-1:0]),
      .rd_addr_b (pos_next1[ADDR_W-1:0]),
      .rd_data_a (s0),
      .rd_data_b (s1)
   );

   // interpolation and gain datapath
   assign diff_w = {s1[15], s1} - {s0[15], s0};
   assign prod_w = diff_w * $signed({1'b0, wfrac_ff});
   assign vsum_w = $signed({{2{s0[15]}}, s0, 16'h0000}) + prod_ff;
   assign p_w    = v_ff * $signed({1'b0, gain_ff});
   assign psum_w = p_ff + ROUND_HALF;
   assign c_w    = psum_w[48:31];

   assign sum_l  = {res_left_ff[23], res_left_ff} + {{7{c_w[17]}}, c_w};
   assign sum_r  = {res_right_ff[23], res_right_ff} + {{7{c_w[17]}}, c_w};
   assign clip_l = (sum_l[24] != sum_l[23]);
   assign clip_r = (sum_r[24] != sum_r[23]);
   assign sat_l  = clip_l ? (sum_l[24] ? MIX_MIN : MIX_MAX) : sum_l[23:0];
   assign sat_r  = clip_r ? (sum_r[24] ? MIX_MIN : MIX_MAX) : sum_r[23:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         wfrac_ff     <= frac_ff;
         res_left_ff  <= req_mix_in_left;
         res_right_ff <= req_mix_in_right;
         res_ended_ff <= (req_command == CMD_MIX) && ended_w;
         res_clip_ff  <= 1'b0;
      end
      if (state_ff == S_LERP) begin
         prod_ff <= prod_w;
      end
      if (state_ff == S_BLEND) begin
         v_ff <= vsum_w[31:0];
      end
      if (state_ff == S_GAIN) begin
         p_ff <= p_w;
      end
      if (state_ff == S_ROUND) begin
         res_left_ff  <= sat_l;
         res_right_ff <= sat_r;
         res_clip_ff  <= clip_l || clip_r;
      end
   end

   // state, position and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= 17'd0;
         frac_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         frac_ff  <= frac_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == S_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_left_ff  <= res_left_ff;
            rsp_right_ff <= res_right_ff;
            rsp_ended_ff <= res_ended_ff;
            rsp_clip_ff  <= res_clip_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mix_out_left  = rsp_left_ff;
   assign rsp_mix_out_right = rsp_right_ff;
   assign rsp_sample_ended  = rsp_ended_ff;
   assign rsp_clipped       = rsp_clip_ff;

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LENGTH_RST;
         step_ff <= STEP_RST;
         gain_ff <= GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_LENGTH: len_ff  <= csr_pwdata[16:0];
            REG_STEP:   step_ff <= csr_pwdata[23:0];
            REG_GAIN:   gain_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LENGTH: csr_prdata = {15'd0, len_ff};
         REG_STEP:   csr_prdata = {8'd0, step_ff};
         REG_GAIN:   csr_prdata = {16'd0, gain_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   `RVML_ASSERT_IMPL(a_end_no_clip, clock, reset, rsp_valid_ff, !(rsp_ended_ff && rsp_clip_ff), "ended item flagged as clipped")
   `RVML_ASSERT_IMPL(a_clip_sat, clock, reset, rsp_valid_ff && rsp_clip_ff, rsp_left_ff == MIX_MAX || rsp_left_ff == MIX_MIN || rsp_right_ff == MIX_MAX || rsp_right_ff == MIX_MIN, "clipped item without a saturated channel")
   `RVML_ASSERT_NEXT(a_end_holds_pos, clock, reset, accept && req_command == CMD_MIX && ended_w, $stable(pos_ff) && $stable(frac_ff), "ended mix moved the read point")
   `RVML_ASSERT_NEXT(a_fin_waits, clock, reset, state_ff == S_FIN && !out_free, state_ff == S_FIN && rsp_valid_ff, "finished item dropped while output stalled")

endmodule

[tb/tb_resample_voice_mix_lerp_top.sv]
// ----------------------------------------------------------------------------
// tb_resample_voice_mix_lerp_top
// self-checking bench for the interpolating voice mixer, directed and random items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_resample_voice_mix_lerp_top;
   import rvml_pkg::*;

   localparam int      SAMPLE_DEPTH  = 65536;
   localparam int      DRAIN_CYCLES  = 12;
   localparam int      RANDOM_PHASES = 8;
   localparam int      RANDOM_ITEMS  = 1100;
   localparam cmd_type CMD_UNUSED    = 2'd3;

   typedef struct {
      mix_type left;
      mix_type right;
      logic    ended;
      logic    clipped;
   } mix_frame_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cmd_type      req_command = CMD_LOAD;
   logic [15:0]  req_sample_address = '0;
   sample_type   req_sample_value = '0;
   logic [15:0]  req_start_position = '0;
   logic [15:0]  req_start_fraction = '0;
   mix_type      req_mix_in_left = '0;
   mix_type      req_mix_in_right = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mix_type      rsp_mix_out_left;
   mix_type      rsp_mix_out_right;
   logic         rsp_sample_ended;
   logic         rsp_clipped;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   csr_addr_type csr_paddr = '0;
   csr_data_type csr_pwdata = '0;
   csr_data_type csr_prdata;
   logic         csr_pready;

   // predicted voice state
   sample_type   voice_mem [0:SAMPLE_DEPTH-1];
   bit           word_written [0:SAMPLE_DEPTH-1];
   logic [16:0]  play_pos = '0;
   logic [15:0]  play_frac = '0;
   logic [16:0]  cfg_length = LENGTH_RST;
   logic [23:0]  cfg_step = STEP_RST;
   logic [15:0]  cfg_gain = GAIN_RST;

   mix_frame_type pending_frames [$];
   int           error_count = 0;
   int           item_count = 0;
   int           stall_hold = 0;
   bit           idle_on = 1'b1;
   bit           stall_on = 1'b1;

   resample_voice_mix_lerp_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_sample_address (req_sample_address),
      .req_sample_value   (req_sample_value),
      .req_start_position (req_start_position),
      .req_start_fraction (req_start_fraction),
      .req_mix_in_left    (req_mix_in_left),
      .req_mix_in_right   (req_mix_in_right),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mix_out_left   (rsp_mix_out_left),
      .rsp_mix_out_right  (rsp_mix_out_right),
      .rsp_sample_ended   (rsp_sample_ended),
      .rsp_clipped        (rsp_clipped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic mix_type rand_mix();
      case ($urandom_range(0, 9))
         0: return MIX_MAX - mix_type'($urandom_range(0, 70000));
         1: return MIX_MIN + mix_type'($urandom_range(0, 70000));
         default: return mix_type'($urandom);
      endcase
   endfunction

   function automatic int unsigned eff_length();
      return (cfg_length > 17'd65536) ? SAMPLE_DEPTH : cfg_length;
   endfunction

   function automatic mix_frame_type voice_mix_predict(input cmd_type cmd,
         input logic [15:0] addr, input sample_type value, input logic [15:0] pos,
         input logic [15:0] frac, input mix_type in_l, input mix_type in_r);
      mix_frame_type r;
      longint      s0, s1, v, prod, contrib, sum_l, sum_r;
      logic [16:0] f;
      r.left = in_l;
      r.right = in_r;
      r.ended = 1'b0;
      r.clipped = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            voice_mem[addr] = value;
            word_written[addr] = 1'b1;
         end
         CMD_SET: begin
            play_pos = {1'b0, pos};
            play_frac = frac;
         end
         CMD_MIX: begin
            if (int'(play_pos) + 1 >= int'(eff_length())) begin
               r.ended = 1'b1;
            end else begin
               s0 = voice_mem[play_pos];
               s1 = voice_mem[play_pos + 17'd1];
               v = s0 * 65536 + (s1 - s0) * longint'(play_frac);
               prod = v * longint'(cfg_gain);
               // floor after adding half gives round half up
               contrib = (prod + 64'sd1073741824) >>> 31;
               sum_l = longint'(in_l) + contrib;
               sum_r = longint'(in_r) + contrib;
               r.left = (sum_l > longint'(MIX_MAX)) ? MIX_MAX :
                        (sum_l < longint'(MIX_MIN)) ? MIX_MIN : mix_type'(sum_l);
               r.right = (sum_r > longint'(MIX_MAX)) ? MIX_MAX :
                         (sum_r < longint'(MIX_MIN)) ? MIX_MIN : mix_type'(sum_r);
               r.clipped = (longint'(r.left) != sum_l) || (longint'(r.right) != sum_r);
               f = {1'b0, play_frac} + {1'b0, cfg_step[15:0]};
               play_pos = play_pos + {9'd0, cfg_step[23:16]} + {16'd0, f[16]};
               play_frac = f[15:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < 100) $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_item(input cmd_type cmd, input logic [15:0] addr,
         input sample_type value, input logic [15:0] pos, input logic [15:0] frac,
         input mix_type in_l, input mix_type in_r);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sample_address <= addr;
      req_sample_value <= value;
      req_start_position <= pos;
      req_start_fraction <= frac;
      req_mix_in_left <= in_l;
      req_mix_in_right <= in_r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_frames.push_back(voice_mix_predict(cmd, addr, value, pos, frac, in_l, in_r));
      item_count++;
   endtask

   task automatic send_set(input logic [15:0] pos, input logic [15:0] frac);
      send_item(CMD_SET, 16'($urandom), rand_sample(), pos, frac, rand_mix(), rand_mix());
   endtask

   // load any word the next mix reads that was never written
   task automatic send_mix(input mix_type in_l, input mix_type in_r);
      int unsigned p;
      p = play_pos;
      if (p + 1 < eff_length()) begin
         if (!word_written[p])
            send_item(CMD_LOAD, 16'(p), rand_sample(), 16'($urandom), 16'($urandom),
                      rand_mix(), rand_mix());
         if (!word_written[p + 1])
            send_item(CMD_LOAD, 16'(p + 1), rand_sample(), 16'($urandom), 16'($urandom),
                      rand_mix(), rand_mix());
      end
      send_item(CMD_MIX, 16'($urandom), rand_sample(), 16'($urandom), 16'($urandom),
                in_l, in_r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_LENGTH: cfg_length = value[16:0];
         REG_STEP:   cfg_step = value[23:0];
         REG_GAIN:   cfg_gain = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [16:0] len, input logic [23:0] step,
         input logic [15:0] g);
      wait_drained();
      write_reg(REG_LENGTH, {15'd0, len});
      write_reg(REG_STEP, {8'd0, step});
      write_reg(REG_GAIN, {16'd0, g});
   endtask

   // length is zero after reset, so every mix ends and every item passes through
   task automatic test_passthrough_after_reset();
      send_item(CMD_MIX, 16'hFFFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, MIX_MAX, MIX_MIN);
      send_item(CMD_UNUSED, 16'hFFFF, 16'shFFFF, 16'hFFFF, 16'hFFFF, MIX_MIN, MIX_MAX);
      send_item(CMD_SET, 16'h0000, 16'sh0000, 16'h0000, 16'h0000, 24'sh000000, 24'shFFFFFF);
      send_item(CMD_LOAD, 16'h0000, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 24'sh000001, MIX_MAX);
   endtask

   task automatic test_lerp_and_clipping();
      set_config(17'd4, 24'h010000, 16'hFFFF);
      send_item(CMD_LOAD, 16'h0001, 16'sh8000, 16'h0000, 16'h0000, MIX_MIN, MIX_MIN);
      send_item(CMD_LOAD, 16'h0002, 16'sh7FFF, 16'h0000, 16'h0000, MIX_MAX, MIX_MAX);
      send_item(CMD_LOAD, 16'h0003, 16'sh0001, 16'h0000, 16'h0000, 24'sh0, 24'sh0);
      send_set(16'h0000, 16'h0000);
      send_mix(MIX_MAX, MIX_MIN);
      send_mix(MIX_MIN, MIX_MAX);
      send_mix(24'sh000000, 24'sh000000);
      send_mix(24'sh003039, 24'shFFCFC7);
      send_set(16'h0001, 16'hFFFF);
      send_mix(24'sh000000, 24'sh000000);
      send_mix(MIX_MAX, MIX_MIN);
   endtask

   task automatic test_length_limits();
      // length beyond the memory, largest step, zero gain
      set_config(17'h1FFFF, 24'hFFFFFF, 16'h0000);
      send_set(16'hFFFE, 16'h8000);
      send_mix(rand_mix(), rand_mix());
      send_mix(rand_mix(), rand_mix());
      send_set(16'hFFFF, 16'h0000);
      send_mix(rand_mix(), rand_mix());
      // a single word can never be interpolated
      set_config(17'd1, 24'h000000, GAIN_RST);
      send_set(16'h0000, 16'h0000);
      send_mix(rand_mix(), rand_mix());
      // zero step stays on the same pair
      set_config(17'd2, 24'h000000, GAIN_RST);
      send_set(16'h0000, 16'h1234);
      send_mix(rand_mix(), rand_mix());
      send_mix(rand_mix(), rand_mix());
   endtask

   task automatic random_item();
      int          r;
      int unsigned lim;
      logic [15:0] p;
      r = $urandom_range(0, 99);
      lim = eff_length();
      if (r < 55) begin
         send_mix(rand_mix(), rand_mix());
      end else if (r < 72) begin
         if (lim >= 2 && $urandom_range(0, 4) != 0) p = 16'($urandom_range(0, lim - 2));
         else p = 16'($urandom);
         send_set(p, 16'($urandom));
      end else if (r < 95) begin
         if (lim >= 1 && $urandom_range(0, 9) < 7) p = 16'($urandom_range(0, lim - 1));
         else p = 16'($urandom);
         send_item(CMD_LOAD, p, rand_sample(), 16'($urandom), 16'($urandom),
                   rand_mix(), rand_mix());
      end else begin
         send_item(CMD_UNUSED, 16'($urandom), rand_sample(), 16'($urandom), 16'($urandom),
                   rand_mix(), rand_mix());
      end
   endtask

   task automatic test_random_traffic();
      int unsigned len;
      logic [23:0] step;
      logic [15:0] g;
      int          target;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0: len = $urandom_range(2, 16);
            1: len = SAMPLE_DEPTH;
            2: len = $urandom_range(17, 2048);
            3: len = $urandom_range(65537, 131071);
            4: len = $urandom_range(0, 1);
            default: len = $urandom_range(2, 300);
         endcase
         if ($urandom_range(0, 4) == 0) step = 24'($urandom);
         else step = 24'($urandom_range(0, 24'h02FFFF));
         case ($urandom_range(0, 5))
            0: g = 16'h0000;
            1: g = 16'hFFFF;
            default: g = 16'($urandom);
         endcase
         set_config(17'(len), step, g);
         idle_on = (phase % 3 != 2);
         stall_on = idle_on;
         target = item_count + RANDOM_ITEMS / RANDOM_PHASES;
         while (item_count < target) random_item();
      end
      wait_drained();
   endtask

   // output side back-pressure
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall <= stall_on && ($urandom_range(0, 2) == 0);
         stall_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      mix_frame_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_frames.size() == 0) begin
            report_error("result with no item pending");
         end else begin
            want = pending_frames.pop_front();
            if (rsp_mix_out_left !== want.left)
               report_error($sformatf("left got %0d expected %0d",
                                      rsp_mix_out_left, want.left));
            if (rsp_mix_out_right !== want.right)
               report_error($sformatf("right got %0d expected %0d",
                                      rsp_mix_out_right, want.right));
            if (rsp_sample_ended !== want.ended)
               report_error($sformatf("sample_ended got %b expected %b",
                                      rsp_sample_ended, want.ended));
            if (rsp_clipped !== want.clipped)
               report_error($sformatf("clipped got %b expected %b",
                                      rsp_clipped, want.clipped));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough_after_reset();
      test_lerp_and_clipping();
      test_length_limits();
      test_random_traffic();
      while (pending_frames.size() != 0) begin
         void'(pending_frames.pop_front());
         report_error("expected result never arrived");
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/rvml_pkg.sv
hdl/rvml_sample_ram.sv
hdl/resample_voice_mix_lerp_top.sv
tb/tb_resample_voice_mix_lerp_top.sv
